### src/msd_pkg.sv
// package for the multi-scheme symbol demapper
// holds sample widths, rotation coefficients, scheme codes and register indexes
// no dependencies
package msd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ROT_BITS = SAMPLE_BITS + 1;
    localparam int THRESH_BITS = 15;
    localparam int CMP_BITS = ((ROT_BITS > THRESH_BITS) ? ROT_BITS : THRESH_BITS) + 2;
    localparam int SYMBOL_BITS = 4;
    localparam int COEF_BITS = 15;
    localparam int FRAC_BITS = 15;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 15;
    localparam int MODE_BITS = 3;

    localparam logic [COEF_BITS-1:0] COS_PI4 = 15'd23170;
    localparam logic [COEF_BITS-1:0] SIN_PI4 = 15'd23170;
    localparam logic [COEF_BITS-1:0] COS_PI8 = 15'd30274;
    localparam logic [COEF_BITS-1:0] SIN_PI8 = 15'd12540;

    typedef enum logic [MODE_BITS-1:0] {
        SCHEME_BPSK  = 3'd0,
        SCHEME_QPSK  = 3'd1,
        SCHEME_QAM4  = 3'd2,
        SCHEME_PSK8  = 3'd3,
        SCHEME_QAM16 = 3'd4,
        SCHEME_PAM4  = 3'd5
    } scheme_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCHEME_MODE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_QAM16_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAM4_THRESHOLD = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic signed [ROT_BITS-1:0] i;
        logic signed [ROT_BITS-1:0] q;
    } rot_pair_t;

endpackage

### src/msd_rotate.sv
// counter-clockwise rotation of one i/q pair by an unsigned q0.15 cosine and sine
// quotients by 2^15 truncate toward zero; depends on msd_pkg
module msd_rotate (
    input  msd_pkg::sample_t                    i_in,
    input  msd_pkg::sample_t                    q_in,
    input  logic [msd_pkg::COEF_BITS-1:0]       cos_coef,
    input  logic [msd_pkg::COEF_BITS-1:0]       sin_coef,
    output msd_pkg::rot_pair_t                  rotated
);
    import msd_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS + 1;
    localparam int SUM_BITS = PROD_BITS + 1;

    logic signed [PROD_BITS-1:0] i_ext;
    logic signed [PROD_BITS-1:0] q_ext;
    logic signed [PROD_BITS-1:0] c_ext;
    logic signed [PROD_BITS-1:0] s_ext;
    logic signed [PROD_BITS-1:0] prod_ic;
    logic signed [PROD_BITS-1:0] prod_qs;
    logic signed [PROD_BITS-1:0] prod_is;
    logic signed [PROD_BITS-1:0] prod_qc;
    logic signed [SUM_BITS-1:0]  sum_i;
    logic signed [SUM_BITS-1:0]  sum_q;
    logic signed [SUM_BITS-1:0]  bias_i;
    logic signed [SUM_BITS-1:0]  bias_q;
    logic signed [SUM_BITS-1:0]  shift_i;
    logic signed [SUM_BITS-1:0]  shift_q;

    localparam logic signed [SUM_BITS-1:0] ROUND_IN = SUM_BITS'((1 << FRAC_BITS) - 1);

    assign i_ext = PROD_BITS'(i_in);
    assign q_ext = PROD_BITS'(q_in);
    assign c_ext = PROD_BITS'(signed'({1'b0, cos_coef}));
    assign s_ext = PROD_BITS'(signed'({1'b0, sin_coef}));

    assign prod_ic = i_ext * c_ext;
    assign prod_qs = q_ext * s_ext;
    assign prod_is = i_ext * s_ext;
    assign prod_qc = q_ext * c_ext;

    assign sum_i = SUM_BITS'(prod_ic) - SUM_BITS'(prod_qs);
    assign sum_q = SUM_BITS'(prod_is) + SUM_BITS'(prod_qc);

    // truncate toward zero
    assign bias_i = sum_i[SUM_BITS-1] ? sum_i + ROUND_IN : sum_i;
    assign bias_q = sum_q[SUM_BITS-1] ? sum_q + ROUND_IN : sum_q;
    assign shift_i = bias_i >>> FRAC_BITS;
    assign shift_q = bias_q >>> FRAC_BITS;

    assign rotated.i = shift_i[ROT_BITS-1:0];
    assign rotated.q = shift_q[ROT_BITS-1:0];

endmodule

### src/multi_scheme_symbol_demapper_core.sv
// multi-scheme hard-decision symbol demapper, top level
// input register, rotation and decision logic, result register
// depends on msd_pkg and msd_rotate
//
// usage:
//   sample channel: sample_valid / sample_stall with in_phase and quadrature.
//   symbol channel: symbol_valid / symbol_stall with symbol.
//   a word moves at a rising edge where valid is high and stall is low.
//   configuration: cfg_write with cfg_index and cfg_data, written only while idle
//     by the user; the block itself does not enforce it. index 0 scheme_mode,
//     1 qam16_level_threshold, 2 pam4_level_threshold.
//   throughput: one sample per cycle while the symbol side does not stall,
//     set by the single decision stage between the input and result registers.
//   reset: both registers empty, all configuration registers zero (bpsk).
//   stall: a stalled symbol holds; an empty input register still takes one more
//     sample, then sample_stall rises until the symbol is taken.
module multi_scheme_symbol_demapper_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  msd_pkg::sample_t                    in_phase,
    input  msd_pkg::sample_t                    quadrature,
    output logic                                symbol_valid,
    input  logic                                symbol_stall,
    output logic [msd_pkg::SYMBOL_BITS-1:0]     symbol,
    input  logic                                cfg_write,
    input  logic [msd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [msd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import msd_pkg::*;

    logic [MODE_BITS-1:0]     mode_reg;
    logic [THRESH_BITS-1:0]   qam16_thresh_reg;
    logic [THRESH_BITS-1:0]   pam4_thresh_reg;

    logic                     in_full_reg;
    logic                     in_full_next;
    sample_t                  i_reg;
    sample_t                  q_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [SYMBOL_BITS-1:0]   symbol_reg;
    logic [SYMBOL_BITS-1:0]   symbol_next;

    logic                     accept;
    logic                     advance;

    rot_pair_t                rot4;
    rot_pair_t                rot8;

    logic signed [CMP_BITS-1:0] i_c;
    logic signed [CMP_BITS-1:0] q_c;
    logic signed [CMP_BITS-1:0] r4i_c;
    logic signed [CMP_BITS-1:0] r4q_c;
    logic signed [CMP_BITS-1:0] r8i_c;
    logic signed [CMP_BITS-1:0] r8q_c;
    logic signed [CMP_BITS-1:0] t16_c;
    logic signed [CMP_BITS-1:0] tp_c;
    logic                       diag;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            qam16_thresh_reg <= '0;
            pam4_thresh_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCHEME_MODE:     mode_reg <= cfg_data[MODE_BITS-1:0];
                CFG_QAM16_THRESHOLD: qam16_thresh_reg <= cfg_data[THRESH_BITS-1:0];
                CFG_PAM4_THRESHOLD:  pam4_thresh_reg <= cfg_data[THRESH_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // handshake
    assign advance = in_full_reg && (!out_valid_reg || !symbol_stall);
    assign sample_stall = in_full_reg && out_valid_reg && symbol_stall;
    assign accept = sample_valid && !sample_stall;
    assign in_full_next = accept || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && symbol_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            i_reg <= in_phase;
            q_reg <= quadrature;
        end
        if (advance)
        begin
            symbol_reg <= symbol_next;
        end
    end

    msd_rotate u_rot4 (
        .i_in     (i_reg),
        .q_in     (q_reg),
        .cos_coef (COS_PI4),
        .sin_coef (SIN_PI4),
        .rotated  (rot4)
    );

    msd_rotate u_rot8 (
        .i_in     (i_reg),
        .q_in     (q_reg),
        .cos_coef (COS_PI8),
        .sin_coef (SIN_PI8),
        .rotated  (rot8)
    );

    assign i_c = CMP_BITS'(i_reg);
    assign q_c = CMP_BITS'(q_reg);
    assign r4i_c = CMP_BITS'(rot4.i);
    assign r4q_c = CMP_BITS'(rot4.q);
    assign r8i_c = CMP_BITS'(rot8.i);
    assign r8q_c = CMP_BITS'(rot8.q);
    assign t16_c = CMP_BITS'(signed'({1'b0, qam16_thresh_reg}));
    assign tp_c = CMP_BITS'(signed'({1'b0, pam4_thresh_reg}));

    assign diag = ((r8q_c > r8i_c) && (-r8i_c > r8q_c))
               || ((r8q_c > -r8i_c) && (r8i_c > r8q_c));

    // decision
    always_comb
    begin
        symbol_next = '0;
        case (mode_reg)
            SCHEME_BPSK:
                symbol_next = {3'b000, (i_c > 0)};
            SCHEME_QPSK:
                symbol_next = {2'b00, (r4i_c <= 0), (r4q_c <= 0)};
            SCHEME_QAM4:
                symbol_next = {2'b00, (i_c <= 0), (q_c <= 0)};
            SCHEME_PSK8:
                symbol_next = {1'b0, (r8i_c <= 0), (r8q_c <= 0), !diag};
            SCHEME_QAM16:
                symbol_next = {(i_c > 0),
                               ((i_c <= t16_c) && (i_c >= -t16_c)),
                               (q_c <= 0),
                               ((q_c <= t16_c) && (q_c >= -t16_c))};
            SCHEME_PAM4:
                if (i_c > 0)
                    symbol_next = {3'b000, (i_c <= tp_c)};
                else
                    symbol_next = {2'b00, 1'b1, (i_c >= -tp_c)};
            default:
                symbol_next = '0;
        endcase
    end

    assign symbol_valid = out_valid_reg;
    assign symbol = symbol_reg;

endmodule

### src/msd_checker.sv
// port-level checks for the symbol demapper top level
// bound to multi_scheme_symbol_demapper_core; depends on msd_pkg
module msd_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    input  logic                                sample_stall,
    input  logic                                symbol_valid,
    input  logic                                symbol_stall,
    input  logic [msd_pkg::SYMBOL_BITS-1:0]     symbol
);
    import msd_pkg::*;

    // a held symbol stays
    a_symbol_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (symbol_valid && symbol_stall) |=> (symbol_valid && $stable(symbol)))
        else $error("stalled symbol word changed");

    // input stalls only when the result side is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (symbol_valid && symbol_stall))
        else $error("sample_stall without a stalled symbol");

    // with an empty output, an accepted sample reaches symbol_valid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall && !symbol_valid) |=> ##1 symbol_valid)
        else $error("accepted sample did not reach the output");

    // after a taken symbol, the input stalls only with a symbol shown
    a_free_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (symbol_valid && !symbol_stall) |=> !sample_stall || symbol_valid)
        else $error("input stalled with empty output");

endmodule

bind multi_scheme_symbol_demapper_core msd_checker u_msd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall),
    .symbol       (symbol)
);
